### rtl/bcc_pkg.sv
// Shared types, constants and functions of the bech32 checksum codec.
package bcc_pkg;

  localparam int MAX_HRP_LEN_DEF = 83;
  localparam int MAX_STRING_LEN  = 90;
  localparam int QUEUE_DEPTH     = 2;

  localparam int DC_W = 7;
  localparam logic [DC_W-1:0] DC_MAX = '1;

  localparam logic [29:0] BECH32_CONST  = 30'h0000_0001;
  localparam logic [29:0] BECH32M_CONST = 30'h2bc8_30a3;

  localparam logic [4:0][29:0] GEN = {
    30'h2a14_62b3, 30'h3d42_33dd, 30'h1ea1_19fa, 30'h2650_8e6d, 30'h3b6a_57b2
  };

  // charset, first character in the top byte
  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ERR_CHAR = 2'd1;
  localparam logic [1:0] ERR_SUM  = 2'd2;
  localparam logic [1:0] ERR_LEN  = 2'd3;

  localparam logic [2:0] CHK_LAST = 3'd5;

  localparam logic KIND_HRP  = 1'b0;
  localparam logic KIND_DATA = 1'b1;
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_VERIFY = 1'b1;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_REPLAY,
    BS_DATA,
    BS_ZERO,
    BS_CHK
  } back_state_t;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic       is_data;
    logic       op;
    logic       bad;
    logic [2:0] hi;
    logic [4:0] sym;
    logic       variant;
    logic       last;
  } item_t;

  function automatic logic [6:0] charset_char(input logic [4:0] s);
    return CHARSET[{~s, 3'b000} +: 7];
  endfunction

  // one BCH polymod step
  function automatic logic [29:0] polymod_step(input logic [29:0] r, input logic [4:0] s);
    logic [29:0] x;
    x = {r[24:0], s};
    for (int j = 0; j < 5; j++) begin
      if (r[25 + j]) begin
        x = x ^ GEN[j];
      end
    end
    return x;
  endfunction

endpackage

### rtl/bcc_front.sv
// Input side: range-checks each beat into a queue item, lowercasing in verify mode and charset-decoding verify data.
module bcc_front
  import bcc_pkg::*;
(
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        op,
  input  logic        q_full,
  output logic        push,
  output item_t       item
);

  logic [7:0] value;
  logic [7:0] low_c;
  logic [7:0] c;
  logic       hit;
  logic [4:0] dsym;

  assign value     = in_tdata[7:0];
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    low_c = (value >= 8'd65 && value <= 8'd90) ? value + 8'd32 : value;
    c     = (op == OP_VERIFY) ? low_c : value;
    hit   = 1'b0;
    dsym  = '0;
    for (int i = 0; i < 32; i++) begin
      if (!low_c[7] && charset_char(5'(i)) == low_c[6:0]) begin
        hit  = 1'b1;
        dsym = 5'(i);
      end
    end

    item.is_data = in_tuser;
    item.op      = op;
    item.variant = in_tdata[8];
    item.last    = in_tlast;
    item.hi      = c[7:5];
    if (in_tuser == KIND_HRP) begin
      item.bad = (c < 8'd33) || (c > 8'd126);
      item.sym = c[4:0];
    end else if (op == OP_ENCODE) begin
      item.bad = value > 8'd31;
      item.sym = value[4:0];
    end else begin
      item.bad = !hit;
      item.sym = dsym;
    end
  end

endmodule

### rtl/bcc_queue.sv
// Short item queue between front and back.
module bcc_queue
  import bcc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t item_in,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slot_r [QUEUE_DEPTH];
  logic [QA_W-1:0]   wp_r, wp_nxt;
  logic [QA_W-1:0]   rp_r, rp_nxt;
  logic [QC_W-1:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QC_W'(QUEUE_DEPTH));
  assign head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = (wp_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + QA_W'(1);
    end
    if (pop && !empty) begin
      rp_nxt = (rp_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + QA_W'(1);
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wp_r] <= item_in;
    end
  end

endmodule

### rtl/bcc_back.sv
// Execution side: polymod residue, HRP store and replay, checksum emit, output register.
module bcc_back
  import bcc_pkg::*;
#(
  parameter int MAX_HRP_LEN = MAX_HRP_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  item_t      head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [6:0] out_char,
  output logic [1:0] out_status,
  output logic       out_variant,
  output logic       out_final
);

  localparam int HRP_AW = (MAX_HRP_LEN > 1) ? $clog2(MAX_HRP_LEN) : 1;
  localparam int HC_W   = $clog2(MAX_HRP_LEN + 1);
  localparam int TOT_W  = $clog2(MAX_HRP_LEN + 135);

  back_state_t       state_r, state_nxt;
  logic [29:0]       res_r, res_nxt;
  logic [HC_W-1:0]   hc_r, hc_nxt;
  logic [DC_W-1:0]   dc_r, dc_nxt;
  logic              exp_r, exp_nxt;
  logic [1:0]        err_r, err_nxt;
  logic [HRP_AW-1:0] idx_r, idx_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  item_t             cur_r, cur_nxt;

  logic              ov_r, ov_nxt;
  logic [6:0]        ochar_r, ochar_nxt;
  logic [1:0]        ostat_r, ostat_nxt;
  logic              ovar_r, ovar_nxt;
  logic              ofin_r, ofin_nxt;

  logic [4:0]        mem [MAX_HRP_LEN];
  logic [4:0]        rdata_r;
  logic              we;
  logic [HRP_AW-1:0] waddr;
  logic [HRP_AW-1:0] raddr;

  logic              out_free;
  logic              step_go;
  item_t             s;
  logic [DC_W-1:0]   dc_n;
  logic [29:0]       r1;
  logic [TOT_W-1:0]  total;
  logic              found;
  logic              clear;

  assign out_free    = !ov_r || out_tready;
  assign out_tvalid  = ov_r;
  assign out_char    = ochar_r;
  assign out_status  = ostat_r;
  assign out_variant = ovar_r;
  assign out_final   = ofin_r;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    hc_nxt    = hc_r;
    dc_nxt    = dc_r;
    exp_nxt   = exp_r;
    err_nxt   = err_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    ov_nxt    = ov_r && !out_tready;
    ochar_nxt = ochar_r;
    ostat_nxt = ostat_r;
    ovar_nxt  = ovar_r;
    ofin_nxt  = ofin_r;
    pop       = 1'b0;
    we        = 1'b0;
    waddr     = hc_r[HRP_AW-1:0];
    raddr     = '0;
    step_go   = 1'b0;
    clear     = 1'b0;
    s         = head;
    dc_n      = dc_r;
    r1        = res_r;
    total     = '0;
    found     = 1'b0;

    case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          if (head.is_data == KIND_HRP) begin
            pop = 1'b1;
            if (!exp_r) begin
              if (head.bad && err_nxt == ST_OK) err_nxt = ERR_CHAR;
              if (hc_r >= HC_W'(MAX_HRP_LEN)) begin
                if (err_nxt == ST_OK) err_nxt = ERR_LEN;
              end else begin
                we      = 1'b1;
                hc_nxt  = hc_r + HC_W'(1);
                res_nxt = polymod_step(res_r, {2'b00, head.hi});
              end
            end
          end else if (!exp_r) begin
            // first data item: fold the separator, then replay stored low bits
            pop     = 1'b1;
            cur_nxt = head;
            exp_nxt = 1'b1;
            if (hc_r == '0 && err_nxt == ST_OK) err_nxt = ERR_LEN;
            res_nxt   = polymod_step(res_r, 5'd0);
            idx_nxt   = '0;
            state_nxt = (hc_r == '0) ? BS_DATA : BS_REPLAY;
          end else if (out_free) begin
            pop     = 1'b1;
            step_go = 1'b1;
          end
        end
      end
      BS_REPLAY: begin
        res_nxt = polymod_step(res_r, rdata_r);
        idx_nxt = idx_r + HRP_AW'(1);
        raddr   = idx_r + HRP_AW'(1);
        if (HC_W'(idx_r) + HC_W'(1) == hc_r) state_nxt = BS_DATA;
      end
      BS_DATA: begin
        s = cur_r;
        if (out_free) step_go = 1'b1;
      end
      BS_ZERO: begin
        res_nxt = polymod_step(res_r, 5'd0);
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == CHK_LAST) begin
          res_nxt   = res_nxt ^ (cur_r.variant ? BECH32M_CONST : BECH32_CONST);
          cnt_nxt   = '0;
          state_nxt = BS_CHK;
        end
      end
      BS_CHK: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ochar_nxt = charset_char(res_r[29:25]);
          ostat_nxt = err_r;
          ovar_nxt  = cur_r.variant;
          ofin_nxt  = (cnt_r == CHK_LAST);
          res_nxt   = {res_r[24:0], 5'd0};
          cnt_nxt   = cnt_r + 3'd1;
          if (cnt_r == CHK_LAST) begin
            clear     = 1'b1;
            state_nxt = BS_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase

    if (step_go) begin
      dc_n    = (dc_r == DC_MAX) ? dc_r : dc_r + DC_W'(1);
      dc_nxt  = dc_n;
      if (s.bad && err_nxt == ST_OK) err_nxt = ERR_CHAR;
      r1      = polymod_step(res_r, s.bad && s.op == OP_VERIFY ? 5'd0 : s.sym);
      res_nxt = r1;
      ov_nxt  = 1'b1;
      if (s.op == OP_ENCODE) begin
        total = TOT_W'(hc_r) + TOT_W'(dc_n) + TOT_W'(7);
        if (s.last && total > TOT_W'(MAX_STRING_LEN) && err_nxt == ST_OK) err_nxt = ERR_LEN;
        ochar_nxt = charset_char(s.sym);
        ostat_nxt = err_nxt;
        ovar_nxt  = s.variant;
        ofin_nxt  = 1'b0;
        if (s.last) begin
          cur_nxt   = s;
          cnt_nxt   = '0;
          state_nxt = BS_ZERO;
        end else begin
          state_nxt = BS_IDLE;
        end
      end else begin
        total = TOT_W'(hc_r) + TOT_W'(dc_n) + TOT_W'(1);
        if (s.last) begin
          if ((dc_n < DC_W'(6) || total < TOT_W'(8) || total > TOT_W'(MAX_STRING_LEN))
              && err_nxt == ST_OK) err_nxt = ERR_LEN;
          if (r1 == BECH32_CONST) begin
            found = 1'b0;
          end else if (r1 == BECH32M_CONST) begin
            found = 1'b1;
          end else if (err_nxt == ST_OK) begin
            err_nxt = ERR_SUM;
          end
          if (err_nxt != ST_OK) found = 1'b0;
          clear = 1'b1;
        end
        ochar_nxt = '0;
        ostat_nxt = err_nxt;
        ovar_nxt  = found;
        ofin_nxt  = s.last;
        state_nxt = BS_IDLE;
      end
    end

    if (clear) begin
      res_nxt = BECH32_CONST;
      hc_nxt  = '0;
      dc_nxt  = '0;
      exp_nxt = 1'b0;
      err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      res_r   <= BECH32_CONST;
      hc_r    <= '0;
      dc_r    <= '0;
      exp_r   <= 1'b0;
      err_r   <= ST_OK;
      idx_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      hc_r    <= hc_nxt;
      dc_r    <= dc_nxt;
      exp_r   <= exp_nxt;
      err_r   <= err_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    ochar_r <= ochar_nxt;
    ostat_r <= ostat_nxt;
    ovar_r  <= ovar_nxt;
    ofin_r  <= ofin_nxt;
  end

  // HRP low-bit store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= head.sym;
    end
    rdata_r <= mem[raddr];
  end

  // replay only runs once the separator has been folded
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_REPLAY) |-> exp_r)
    else $error("replay without expansion");

  // no error is raised or dropped while the HRP is replayed
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_REPLAY) |=> (err_r == $past(err_r)))
    else $error("error code moved during replay");

  // stored HRP length never passes the store depth
  assert property (@(posedge clk) disable iff (!rst_n)
    hc_r <= HC_W'(MAX_HRP_LEN))
    else $error("hrp count overflow");

  // the checksum phase never counts past six symbols
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_ZERO || state_r == BS_CHK) |-> (cnt_r <= CHK_LAST))
    else $error("checksum counter out of range");

  // a final beat always leaves the string state cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_nxt && ofin_nxt && !(ov_r && !out_tready)) |=> (!exp_r && hc_r == '0))
    else $error("string state not cleared after final beat");

endmodule

### rtl/bech32_checksum_codec.sv
// Top level of the streaming bech32 / bech32m checksum encoder and verifier.
// One string is fed as beats on in_*: HRP characters (in_tuser = 0) first, then
// data items (in_tuser = 1) with in_tlast on the final one. cfg_data selects the
// operation (0 encode, 1 verify); the user must ensure it is written only while
// the block is idle, which the block does not enforce. Each beat is tagged with
// the operation current when it is accepted. A front stage classifies beats
// (lowercasing, range check, charset decode) into a two-entry queue; a back
// engine owns the 30-bit polymod residue, an MAX_HRP_LEN-deep HRP store and the
// output register. A data beat waits on output backpressure; the first data
// beat of a string first folds the separator, then replays the stored HRP low
// bits one per cycle through the store's single read port. An encode last beat
// is followed by folding six zero symbols and then 6 checksum beats, one per
// cycle while out_tready is high. Verify gives one result beat per data beat,
// the final one carrying the verdict. status is the sticky error so far.
module bech32_checksum_codec
  import bcc_pkg::*;
#(
  parameter int MAX_HRP_LEN = MAX_HRP_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,     // operation
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [7:0] value, [8] variant, rest zero
  input  logic        in_tuser,     // [0] kind
  input  logic        in_tlast,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [6:0] out_char, [8:7] status, [9] found_variant
  output logic        out_tlast
);

  logic       op_r;
  logic       push;
  item_t      fr_item;
  item_t      q_head;
  logic       q_empty;
  logic       q_full;
  logic       q_pop;
  logic [6:0] o_char;
  logic [1:0] o_status;
  logic       o_variant;

  // operation register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_ENCODE;
    end else if (cfg_valid) begin
      op_r <= cfg_data;
    end
  end

  bcc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .op        (op_r),
    .q_full    (q_full),
    .push      (push),
    .item      (fr_item)
  );

  bcc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .item_in (fr_item),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  bcc_back #(
    .MAX_HRP_LEN (MAX_HRP_LEN)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .q_empty     (q_empty),
    .pop         (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_char    (o_char),
    .out_status  (o_status),
    .out_variant (o_variant),
    .out_final   (out_tlast)
  );

  // pack result fields, zero padded to two bytes
  assign out_tdata = {6'd0, o_variant, o_status, o_char};

endmodule
